// File: rtl/assert_macros.svh
// assertion helpers shared by the dc offset removal rtl
// every user module has clock and reset ports under these names
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define AST_ALWAYS(name, cond, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

`define AST_IMPLIES(name, pre, post, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error(msg);

`define AST_NEXT(name, pre, post, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);

`endif

// File: rtl/tdcor_pkg.sv
// shared types and constants for the trace dc offset removal block
// no dependencies
package tdcor_pkg;

   localparam int SAMPLE_BITS_DEF  = 16;
   localparam int MAX_WINDOW_DEF   = 64;
   localparam int TRACE_BITS       = 16;
   localparam int WINLEN_BITS      = 7;
   localparam int CSR_INDEX_BITS   = 8;
   localparam int CSR_DATA_BITS    = 16;
   localparam int QUEUE_DEPTH_LOG2 = 2;

   localparam logic [TRACE_BITS-1:0]  TRACE_LEN_RESET = 16'd512;
   localparam logic [WINLEN_BITS-1:0] WIN_LEN_RESET   = 7'd16;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_TRACE_LENGTH  = 8'd0,
      CSR_WINDOW_LENGTH = 8'd1
   } csr_index_type;

   typedef enum logic {
      CMD_PASS  = 1'b0,
      CMD_FLUSH = 1'b1
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic         last_of_trace;
   } cmd_ctl_type;

   localparam int CMD_CTL_BITS = $bits(cmd_ctl_type);

   typedef enum logic [2:0] {
      B_IDLE = 3'd0,
      B_DIV  = 3'd1,
      B_SET  = 3'd2,
      B_RD   = 3'd3,
      B_EMIT = 3'd4
   } back_state_type;

endpackage

// File: rtl/tdcor_queue.sv
// small command queue between the front and back parts
// depends on tdcor_pkg and assert_macros.svh
`include "assert_macros.svh"

module tdcor_queue #(
   parameter int DATA_BITS  = 8,
   parameter int DEPTH_LOG2 = tdcor_pkg::QUEUE_DEPTH_LOG2
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  logic [DATA_BITS-1:0] push_data,
   output logic                 full,
   input  logic                 pop,
   output logic [DATA_BITS-1:0] pop_data,
   output logic                 valid
);
   import tdcor_pkg::*;

   localparam int DEPTH = 1 << DEPTH_LOG2;

   logic [DATA_BITS-1:0]  entries_ff [DEPTH];
   logic [DEPTH_LOG2-1:0] wr_ptr_ff, wr_ptr_in;
   logic [DEPTH_LOG2-1:0] rd_ptr_ff, rd_ptr_in;
   logic [DEPTH_LOG2:0]   count_ff, count_in;

   assign full     = (count_ff == (DEPTH_LOG2+1)'(DEPTH));
   assign valid    = (count_ff != '0);
   assign pop_data = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

   `AST_ALWAYS(a_count_bound, count_ff <= (DEPTH_LOG2+1)'(DEPTH), "queue count over depth")
   `AST_IMPLIES(a_no_pop_empty, pop, count_ff != '0, "queue popped while empty")

endmodule

// File: rtl/tdcor_front.sv
// front part: config registers, trace position, window sum and store writes
// depends on tdcor_pkg and assert_macros.svh
`include "assert_macros.svh"

module tdcor_front #(
   parameter int SAMPLE_BITS = tdcor_pkg::SAMPLE_BITS_DEF,
   parameter int MAX_WINDOW  = tdcor_pkg::MAX_WINDOW_DEF,
   parameter int TDATA_BITS  = ((SAMPLE_BITS + 7) / 8) * 8,
   parameter int CNT_BITS    = $clog2(MAX_WINDOW + 1),
   parameter int IDX_BITS    = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1,
   parameter int SUM_BITS    = SAMPLE_BITS + CNT_BITS
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [TDATA_BITS-1:0]                 req_tdata,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [tdcor_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [tdcor_pkg::CSR_DATA_BITS-1:0]   csr_data,
   output logic                                  q_push,
   output tdcor_pkg::cmd_ctl_type                q_ctl,
   output logic [CNT_BITS-1:0]                   q_win,
   output logic [SUM_BITS-1:0]                   q_data,
   input  logic                                  q_full,
   output logic                                  mem_we,
   output logic [IDX_BITS-1:0]                   mem_addr,
   output logic [SAMPLE_BITS-1:0]                mem_data,
   input  logic                                  flush_done
);
   import tdcor_pkg::*;

   logic [TRACE_BITS-1:0]      trace_len_ff, trace_len_in;
   logic [WINLEN_BITS-1:0]     win_len_ff, win_len_in;
   logic [TRACE_BITS-1:0]      pos_ff, pos_in;
   logic signed [SUM_BITS-1:0] sum_ff, sum_in;
   logic                       busy_ff, busy_in;

   logic [TRACE_BITS-1:0]      trace_eff;
   logic [TRACE_BITS-1:0]      win_raw;
   logic [CNT_BITS-1:0]        win_eff;
   logic [TRACE_BITS-1:0]      win_ext;
   logic signed [SAMPLE_BITS-1:0] sample;
   logic signed [SUM_BITS-1:0] sum_add;
   logic [TRACE_BITS-1:0]      pos_next;
   logic                       in_window;
   logic                       window_full;
   logic                       trace_end;
   logic                       accept;

   always_comb begin
      trace_eff = (trace_len_ff == '0) ? TRACE_BITS'(1) : trace_len_ff;
      win_raw   = (win_len_ff == '0) ? TRACE_BITS'(1) : TRACE_BITS'(win_len_ff);
      if (win_raw > TRACE_BITS'(MAX_WINDOW)) begin
         win_raw = TRACE_BITS'(MAX_WINDOW);
      end
      if (win_raw > trace_eff) begin
         win_raw = trace_eff;
      end
      win_eff = win_raw[CNT_BITS-1:0];
      win_ext = TRACE_BITS'(win_eff);
   end

   assign sample      = signed'(req_tdata[SAMPLE_BITS-1:0]);
   assign sum_add     = sum_ff + SUM_BITS'(sample);
   assign pos_next    = pos_ff + 1'b1;
   assign in_window   = (pos_ff < win_ext);
   assign window_full = (pos_next == win_ext);
   assign trace_end   = (pos_next >= trace_eff);

   assign csr_ready  = 1'b1;
   assign req_tready = !q_full && !(in_window && busy_ff) && !csr_valid;
   assign accept     = req_tvalid && req_tready;

   assign mem_we   = accept && in_window;
   assign mem_addr = pos_ff[IDX_BITS-1:0];
   assign mem_data = sample;

   always_comb begin
      q_push            = accept && (!in_window || window_full);
      q_ctl.kind        = in_window ? CMD_FLUSH : CMD_PASS;
      q_ctl.last_of_trace = trace_end;
      q_win             = win_eff;
      q_data            = in_window ? sum_add : SUM_BITS'(sample);
   end

   always_comb begin
      trace_len_in = trace_len_ff;
      win_len_in   = win_len_ff;
      pos_in       = pos_ff;
      sum_in       = sum_ff;
      busy_in      = busy_ff;
      if (flush_done) begin
         busy_in = 1'b0;
      end
      if (csr_valid) begin
         if (csr_index == CSR_TRACE_LENGTH) begin
            trace_len_in = csr_data[TRACE_BITS-1:0];
            pos_in       = '0;
            sum_in       = '0;
         end else if (csr_index == CSR_WINDOW_LENGTH) begin
            win_len_in = csr_data[WINLEN_BITS-1:0];
            pos_in     = '0;
            sum_in     = '0;
         end
      end else if (accept) begin
         pos_in = pos_next;
         if (in_window) begin
            sum_in = sum_add;
            if (window_full) begin
               busy_in = 1'b1;
            end
         end
         if (trace_end) begin
            pos_in = '0;
            sum_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         trace_len_ff <= TRACE_LEN_RESET;
         win_len_ff   <= WIN_LEN_RESET;
         pos_ff       <= '0;
         sum_ff       <= '0;
         busy_ff      <= 1'b0;
      end else begin
         trace_len_ff <= trace_len_in;
         win_len_ff   <= win_len_in;
         pos_ff       <= pos_in;
         sum_ff       <= sum_in;
         busy_ff      <= busy_in;
      end
   end

   `AST_ALWAYS(a_no_store_while_busy, !(mem_we && busy_ff), "window store written during flush")

endmodule

// File: rtl/tdcor_back.sv
// back part: window store, mean divider, dc removal and output register
// depends on tdcor_pkg and assert_macros.svh
`include "assert_macros.svh"

module tdcor_back #(
   parameter int SAMPLE_BITS = tdcor_pkg::SAMPLE_BITS_DEF,
   parameter int MAX_WINDOW  = tdcor_pkg::MAX_WINDOW_DEF,
   parameter int TDATA_BITS  = ((SAMPLE_BITS + 7) / 8) * 8,
   parameter int CNT_BITS    = $clog2(MAX_WINDOW + 1),
   parameter int IDX_BITS    = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1,
   parameter int SUM_BITS    = SAMPLE_BITS + CNT_BITS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   q_valid,
   output logic                   q_pop,
   input  tdcor_pkg::cmd_ctl_type q_ctl,
   input  logic [CNT_BITS-1:0]    q_win,
   input  logic [SUM_BITS-1:0]    q_data,
   input  logic                   mem_we,
   input  logic [IDX_BITS-1:0]    mem_addr,
   input  logic [SAMPLE_BITS-1:0] mem_data,
   output logic                   flush_done,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [TDATA_BITS-1:0]  rsp_tdata,   // sample_out
   output logic                   rsp_tlast,   // last_of_trace
   output logic                   rsp_tuser    // last_of_run
);
   import tdcor_pkg::*;

   localparam int STEP_BITS = $clog2(SUM_BITS);

   function automatic logic [SAMPLE_BITS-1:0] remove_dc(
      input logic signed [SAMPLE_BITS-1:0] x,
      input logic signed [SAMPLE_BITS-1:0] fl,
      input logic                          frac
   );
      logic signed [SAMPLE_BITS+1:0] d;
      logic signed [SAMPLE_BITS+1:0] hi;
      logic signed [SAMPLE_BITS+1:0] lo;
      d  = (SAMPLE_BITS+2)'(x) - (SAMPLE_BITS+2)'(fl);
      hi = (SAMPLE_BITS+2)'({1'b0, {(SAMPLE_BITS-1){1'b1}}});
      lo = -hi - 1;
      if (frac && d > 0) begin
         d = d - 1;
      end
      if (d > hi) begin
         d = hi;
      end
      if (d < lo) begin
         d = lo;
      end
      return d[SAMPLE_BITS-1:0];
   endfunction

   logic [SAMPLE_BITS-1:0]        mem [MAX_WINDOW];
   logic [SAMPLE_BITS-1:0]        rd_data_ff;

   back_state_type                state_ff, state_in;
   logic                          neg_ff, neg_in;
   logic [SUM_BITS-1:0]           quo_ff, quo_in;
   logic [CNT_BITS-1:0]           rem_ff, rem_in;
   logic [STEP_BITS-1:0]          step_ff, step_in;
   logic [CNT_BITS-1:0]           win_ff, win_in;
   logic                          lot_ff, lot_in;
   logic [CNT_BITS-1:0]           k_ff, k_in;
   logic signed [SAMPLE_BITS-1:0] dc_floor_ff, dc_floor_in;
   logic                          dc_frac_ff, dc_frac_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_BITS-1:0]        rsp_sample_ff, rsp_sample_in;
   logic                          rsp_lot_ff, rsp_lot_in;
   logic                          rsp_lor_ff, rsp_lor_in;

   logic                          out_free;
   logic                          out_load;
   logic                          emit_last;
   logic [CNT_BITS:0]             shifted;
   logic [CNT_BITS:0]             win_wide;
   logic                          ge;
   logic [SUM_BITS-1:0]           mag;
   logic                          rem_nz;
   logic [SUM_BITS-1:0]           floor_full;

   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign emit_last = ((CNT_BITS+1)'(k_ff) + 1'b1) == (CNT_BITS+1)'(win_ff);
   assign shifted   = {rem_ff, quo_ff[SUM_BITS-1]};
   assign win_wide  = (CNT_BITS+1)'(win_ff);
   assign ge        = (shifted >= win_wide);
   assign mag       = q_data[SUM_BITS-1] ? (SUM_BITS'(0) - q_data) : q_data;
   assign rem_nz    = (rem_ff != '0);
   assign floor_full = neg_ff ? (SUM_BITS'(0) - quo_ff - SUM_BITS'(rem_nz)) : quo_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         B_IDLE: begin
            if (q_valid && q_ctl.kind == CMD_FLUSH) begin
               state_in = B_DIV;
            end
         end
         B_DIV: begin
            if (step_ff == '0) begin
               state_in = B_SET;
            end
         end
         B_SET: state_in = B_RD;
         B_RD:  state_in = B_EMIT;
         B_EMIT: begin
            if (out_free) begin
               state_in = emit_last ? B_IDLE : B_RD;
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   // outputs and datapath
   always_comb begin
      q_pop         = 1'b0;
      out_load      = 1'b0;
      flush_done    = 1'b0;
      rsp_sample_in = remove_dc(signed'(rd_data_ff), dc_floor_ff, dc_frac_ff);
      rsp_lot_in    = emit_last && lot_ff;
      rsp_lor_in    = emit_last;
      neg_in        = neg_ff;
      quo_in        = quo_ff;
      rem_in        = rem_ff;
      step_in       = step_ff;
      win_in        = win_ff;
      lot_in        = lot_ff;
      k_in          = k_ff;
      dc_floor_in   = dc_floor_ff;
      dc_frac_in    = dc_frac_ff;
      case (state_ff)
         B_IDLE: begin
            if (q_valid) begin
               if (q_ctl.kind == CMD_FLUSH) begin
                  q_pop   = 1'b1;
                  neg_in  = q_data[SUM_BITS-1];
                  quo_in  = mag;
                  rem_in  = '0;
                  step_in = STEP_BITS'(SUM_BITS - 1);
                  win_in  = q_win;
                  lot_in  = q_ctl.last_of_trace;
               end else if (out_free) begin
                  q_pop         = 1'b1;
                  out_load      = 1'b1;
                  rsp_sample_in = remove_dc(signed'(q_data[SAMPLE_BITS-1:0]),
                                            dc_floor_ff, dc_frac_ff);
                  rsp_lot_in    = q_ctl.last_of_trace;
                  rsp_lor_in    = 1'b1;
               end
            end
         end
         B_DIV: begin
            rem_in  = CNT_BITS'(ge ? (shifted - win_wide) : shifted);
            quo_in  = {quo_ff[SUM_BITS-2:0], ge};
            step_in = step_ff - 1'b1;
         end
         B_SET: begin
            dc_floor_in = signed'(floor_full[SAMPLE_BITS-1:0]);
            dc_frac_in  = rem_nz;
            k_in        = '0;
         end
         B_RD: begin
         end
         B_EMIT: begin
            if (out_free) begin
               out_load   = 1'b1;
               flush_done = emit_last;
               k_in       = k_ff + 1'b1;
            end
         end
         default: begin
         end
      endcase
      rsp_valid_in = out_load ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         rsp_valid_ff <= 1'b0;
         dc_floor_ff  <= '0;
         dc_frac_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         dc_floor_ff  <= dc_floor_in;
         dc_frac_ff   <= dc_frac_in;
      end
   end

   always_ff @(posedge clock) begin
      neg_ff  <= neg_in;
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      step_ff <= step_in;
      win_ff  <= win_in;
      lot_ff  <= lot_in;
      k_ff    <= k_in;
      if (out_load) begin
         rsp_sample_ff <= rsp_sample_in;
         rsp_lot_ff    <= rsp_lot_in;
         rsp_lor_ff    <= rsp_lor_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_addr] <= mem_data;
      end
      rd_data_ff <= mem[k_ff[IDX_BITS-1:0]];
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = TDATA_BITS'(rsp_sample_ff);
   assign rsp_tlast  = rsp_lot_ff;
   assign rsp_tuser  = rsp_lor_ff;

   `AST_IMPLIES(a_k_in_window, state_ff == B_RD || state_ff == B_EMIT, k_ff < win_ff, "window read index past window")
   `AST_IMPLIES(a_load_needs_room, out_load, !rsp_valid_ff || rsp_tready, "output register overwritten")

endmodule

// File: rtl/trace_dc_offset_removal_top.sv
// top level of the trace dc offset removal block
// depends on tdcor_pkg, tdcor_front, tdcor_queue and tdcor_back
//
// channel  direction  ports                                   beat carries
// req      in         req_tvalid req_tready req_tdata         sample_in
// rsp      out        rsp_tvalid rsp_tready rsp_tdata/tlast/tuser  sample_out, trace end, run end
// csr      in         csr_valid csr_ready csr_index csr_data  register write
//
// a beat past the window goes through the queue into the output register, one per cycle
// while the back part is idle and the output is free; a full window goes through the
// one-bit-a-step divider, then each buffered sample through the store read and output register
// the next trace's window beats wait until that flush finishes; passes queue behind it
// synchronous reset clears control state only; the window store is never cleared
// the output register takes a new beat while the previous one is being taken

module trace_dc_offset_removal_top #(
   parameter int SAMPLE_BITS = tdcor_pkg::SAMPLE_BITS_DEF,
   parameter int MAX_WINDOW  = tdcor_pkg::MAX_WINDOW_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [((SAMPLE_BITS+7)/8)*8-1:0]     req_tdata,   // sample_in
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [((SAMPLE_BITS+7)/8)*8-1:0]     rsp_tdata,   // sample_out
   output logic                                 rsp_tlast,   // last_of_trace
   output logic                                 rsp_tuser,   // last_of_run
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [tdcor_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [tdcor_pkg::CSR_DATA_BITS-1:0]  csr_data
);
   import tdcor_pkg::*;

   localparam int TDATA_BITS = ((SAMPLE_BITS + 7) / 8) * 8;
   localparam int CNT_BITS   = $clog2(MAX_WINDOW + 1);
   localparam int IDX_BITS   = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
   localparam int SUM_BITS   = SAMPLE_BITS + CNT_BITS;
   localparam int Q_BITS     = CMD_CTL_BITS + CNT_BITS + SUM_BITS;

   logic                   push;
   cmd_ctl_type            push_ctl;
   logic [CNT_BITS-1:0]    push_win;
   logic [SUM_BITS-1:0]    push_data;
   logic                   q_full;
   logic                   q_valid;
   logic                   q_pop;
   logic [Q_BITS-1:0]      q_in;
   logic [Q_BITS-1:0]      q_out;
   cmd_ctl_type            pop_ctl;
   logic [CNT_BITS-1:0]    pop_win;
   logic [SUM_BITS-1:0]    pop_data;
   logic                   mem_we;
   logic [IDX_BITS-1:0]    mem_addr;
   logic [SAMPLE_BITS-1:0] mem_data;
   logic                   flush_done;

   assign q_in     = {push_ctl, push_win, push_data};
   assign pop_ctl  = cmd_ctl_type'(q_out[Q_BITS-1 -: CMD_CTL_BITS]);
   assign pop_win  = q_out[SUM_BITS +: CNT_BITS];
   assign pop_data = q_out[SUM_BITS-1:0];

   tdcor_front #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .MAX_WINDOW  (MAX_WINDOW),
      .TDATA_BITS  (TDATA_BITS),
      .CNT_BITS    (CNT_BITS),
      .IDX_BITS    (IDX_BITS),
      .SUM_BITS    (SUM_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .q_push     (push),
      .q_ctl      (push_ctl),
      .q_win      (push_win),
      .q_data     (push_data),
      .q_full     (q_full),
      .mem_we     (mem_we),
      .mem_addr   (mem_addr),
      .mem_data   (mem_data),
      .flush_done (flush_done)
   );

   tdcor_queue #(
      .DATA_BITS  (Q_BITS),
      .DEPTH_LOG2 (QUEUE_DEPTH_LOG2)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (q_in),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_out),
      .valid     (q_valid)
   );

   tdcor_back #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .MAX_WINDOW  (MAX_WINDOW),
      .TDATA_BITS  (TDATA_BITS),
      .CNT_BITS    (CNT_BITS),
      .IDX_BITS    (IDX_BITS),
      .SUM_BITS    (SUM_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_pop      (q_pop),
      .q_ctl      (pop_ctl),
      .q_win      (pop_win),
      .q_data     (pop_data),
      .mem_we     (mem_we),
      .mem_addr   (mem_addr),
      .mem_data   (mem_data),
      .flush_done (flush_done),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

// File: tb/sv/testbench.sv
// self-checking testbench for trace_dc_offset_removal_top: random and directed sample traces
// with register changes, checked against a scoreboard that predicts the corrected samples
// depends on tdcor_pkg and the rtl of the block
`timescale 1ns / 100ps

module testbench;
   import tdcor_pkg::*;

   localparam int SAMPLE_W     = SAMPLE_BITS_DEF;
   localparam int DATA_W       = ((SAMPLE_W + 7) / 8) * 8;
   localparam int MAX_WIN      = MAX_WINDOW_DEF;
   localparam longint SAMPLE_MAX = (longint'(1) << (SAMPLE_W - 1)) - 1;
   localparam longint SAMPLE_MIN = -SAMPLE_MAX - 1;
   localparam int SETTLE_CYCLES = 200;
   localparam int HOLD_CYCLES   = 400;
   localparam int QUIET_LIMIT   = 5000;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_UNMAPPED = 8'hFF;

   typedef enum int {
      PACE_NONE     = 0,
      PACE_SENDER   = 1,
      PACE_RECEIVER = 2,
      PACE_BOTH     = 3
   } pace_mode_type;

   typedef struct {
      logic [SAMPLE_W-1:0] sample;
      logic                trace_end;
      logic                run_end;
   } corrected_type;

   class dc_removal_scoreboard;
      logic [TRACE_BITS-1:0]     trace_len;
      logic [WINLEN_BITS-1:0]    win_len;
      logic signed [SAMPLE_W-1:0] window_samples [MAX_WIN];
      longint                    level_sum;
      longint                    level_floor;
      bit                        level_frac;
      int                        position;
      corrected_type             expected_corrected [$];
      int                        mismatches;

      function new();
         trace_len  = TRACE_LEN_RESET;
         win_len    = WIN_LEN_RESET;
         mismatches = 0;
         restart_trace();
      endfunction

      function void restart_trace();
         level_sum   = 0;
         level_floor = 0;
         level_frac  = 1'b0;
         position    = 0;
      endfunction

      function void note_write(logic [CSR_INDEX_BITS-1:0] index, logic [CSR_DATA_BITS-1:0] data);
         if (index == CSR_TRACE_LENGTH) begin
            trace_len = data[TRACE_BITS-1:0];
            restart_trace();
         end else if (index == CSR_WINDOW_LENGTH) begin
            win_len = data[WINLEN_BITS-1:0];
            restart_trace();
         end
      endfunction

      function logic [SAMPLE_W-1:0] subtract_level(longint x);
         longint d;
         d = x - level_floor;
         if (level_frac && d > 0)
            d--;
         if (d > SAMPLE_MAX)
            d = SAMPLE_MAX;
         if (d < SAMPLE_MIN)
            d = SAMPLE_MIN;
         return d[SAMPLE_W-1:0];
      endfunction

      function void note_sample(logic signed [SAMPLE_W-1:0] x);
         int     trace_eff;
         int     win_eff;
         longint quo;
         longint rem;
         trace_eff = (trace_len == 0) ? 1 : int'(trace_len);
         win_eff   = (win_len == 0) ? 1 : int'(win_len);
         if (win_eff > MAX_WIN)
            win_eff = MAX_WIN;
         if (win_eff > trace_eff)
            win_eff = trace_eff;
         if (position < win_eff) begin
            window_samples[position] = x;
            level_sum += x;
            position++;
            if (position == win_eff) begin
               quo = level_sum / win_eff;
               rem = level_sum % win_eff;
               if (rem < 0) begin
                  quo--;
                  rem += win_eff;
               end
               level_floor = quo;
               level_frac  = (rem != 0);
               for (int k = 0; k < win_eff; k++) begin
                  expected_corrected.push_back('{subtract_level(window_samples[k]),
                     (k == win_eff - 1) && (position == trace_eff), k == win_eff - 1});
               end
            end
         end else begin
            position++;
            expected_corrected.push_back('{subtract_level(x), position >= trace_eff, 1'b1});
         end
         if (position >= trace_eff)
            restart_trace();
      endfunction

      function void check_result(logic [DATA_W-1:0] data, logic tlast, logic tuser);
         corrected_type want;
         if (expected_corrected.size() == 0) begin
            report($sformatf("unexpected beat data %h last %b user %b", data, tlast, tuser));
            return;
         end
         want = expected_corrected.pop_front();
         if (data[SAMPLE_W-1:0] !== want.sample)
            report($sformatf("sample_out %h, want %h", data[SAMPLE_W-1:0], want.sample));
         if (tlast !== want.trace_end)
            report($sformatf("last_of_trace %b, want %b", tlast, want.trace_end));
         if (tuser !== want.run_end)
            report($sformatf("last_of_run %b, want %b", tuser, want.run_end));
      endfunction

      function void report(string msg);
         mismatches++;
         if (mismatches <= 40)
            $display("mismatch at %0t: %s", $realtime, msg);
      endfunction

      function int pending();
         return expected_corrected.size();
      endfunction
   endclass

   logic                       clock;
   logic                       reset      = 1'b1;
   logic                       req_tvalid = 1'b0;
   logic                       req_tready;
   logic [DATA_W-1:0]          req_tdata  = '0;   // sample_in
   logic                       rsp_tvalid;
   logic                       rsp_tready = 1'b0;
   logic [DATA_W-1:0]          rsp_tdata;         // sample_out
   logic                       rsp_tlast;         // last_of_trace
   logic                       rsp_tuser;         // last_of_run
   logic                       csr_valid  = 1'b0;
   logic                       csr_ready;
   logic [CSR_INDEX_BITS-1:0]  csr_index  = '0;
   logic [CSR_DATA_BITS-1:0]   csr_data   = '0;

   dc_removal_scoreboard sb;
   int  gap_pct      = 0;
   int  stall_pct    = 0;
   bit  hold_request = 1'b0;

   trace_dc_offset_removal_top u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   task automatic set_pace(input pace_mode_type mode);
      gap_pct   = (mode == PACE_SENDER) ? 60 : (mode == PACE_BOTH) ? 31 : 0;
      stall_pct = (mode == PACE_RECEIVER) ? 60 : (mode == PACE_BOTH) ? 31 : 0;
   endtask

   task automatic send_sample(input logic [SAMPLE_W-1:0] value);
      if ($urandom_range(99) < gap_pct) begin
         req_tvalid <= 1'b0;
         do
            @(negedge clock);
         while ($urandom_range(99) < gap_pct);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      do
         @(posedge clock);
      while (!req_tready);
      sb.note_sample(value);
      @(negedge clock);
   endtask

   task automatic csr_write(input logic [CSR_INDEX_BITS-1:0] index,
                            input logic [CSR_DATA_BITS-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      do
         @(posedge clock);
      while (!csr_ready);
      sb.note_write(index, data);
      @(negedge clock);
   endtask

   // a partly filled window leaves nothing expected, so settle before touching registers
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic configure(input logic [CSR_DATA_BITS-1:0] trace_len,
                            input logic [CSR_DATA_BITS-1:0] win_len);
      wait_drained();
      csr_write(CSR_TRACE_LENGTH, trace_len);
      csr_write(CSR_WINDOW_LENGTH, win_len);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [SAMPLE_W-1:0] random_sample(input logic [SAMPLE_W-1:0] base);
      int pick;
      pick = $urandom_range(7);
      case (pick)
         0: return {1'b1, {(SAMPLE_W-1){1'b0}}};
         1: return {1'b0, {(SAMPLE_W-1){1'b1}}};
         2, 3: return SAMPLE_W'($urandom);
         default: return SAMPLE_W'(base + $urandom_range(2000) - 1000);
      endcase
   endfunction

   initial begin : receiver
      int hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready)
            sb.check_result(rsp_tdata, rsp_tlast, rsp_tuser);
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("CHECK FAILED");
      $finish;
   end

   initial begin : stimulus
      logic [CSR_DATA_BITS-1:0] trace_len;
      logic [CSR_DATA_BITS-1:0] win_len;
      logic [SAMPLE_W-1:0]      base;
      int                       count;
      sb = new();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // register defaults out of reset
      set_pace(PACE_BOTH);
      base = SAMPLE_W'($urandom);
      repeat (24) send_sample(random_sample(base));

      set_pace(PACE_NONE);
      // zero trace and window length act as one
      configure(16'd0, 16'd0);
      send_sample(16'h7FFF);
      send_sample(16'h8000);
      send_sample(16'h0000);

      // overflow past both bounds
      configure(16'd4, 16'd2);
      send_sample(16'h8000);
      send_sample(16'h8000);
      send_sample(16'h7FFF);
      send_sample(16'h0005);
      configure(16'd3, 16'd127);
      send_sample(16'h7FFF);
      send_sample(16'h7FFF);
      send_sample(16'h8000);

      // fractional means, positive and negative
      configure(16'd4, 16'd2);
      send_sample(16'h0001);
      send_sample(16'h0002);
      send_sample(16'hFFFF);
      send_sample(16'h0007);
      send_sample(16'hFFFF);
      send_sample(16'hFFFE);
      send_sample(16'h0000);
      send_sample(16'h0003);

      // unmapped register leaves the window alone, a real write aborts the trace
      configure(16'd6, 16'd3);
      send_sample(16'h0010);
      send_sample(16'hFFF0);
      wait_drained();
      csr_write(CSR_UNMAPPED, 16'hFFFF);
      csr_valid <= 1'b0;
      send_sample(16'h0021);
      send_sample(16'h1234);
      wait_drained();
      csr_write(CSR_WINDOW_LENGTH, 16'd2);
      csr_valid <= 1'b0;
      send_sample(16'hABCD);
      send_sample(16'h4321);

      for (int p = 1; p <= 6; p++) begin
         case (p)
            1: begin
               trace_len = CSR_DATA_BITS'($urandom_range(12, 2));
               win_len   = CSR_DATA_BITS'($urandom_range(4, 1));
               count     = 36;
            end
            2: begin
               trace_len = 16'hFFFF;
               win_len   = CSR_DATA_BITS'(MAX_WIN);
               count     = 80;
            end
            3: begin
               trace_len = CSR_DATA_BITS'($urandom_range(8, 1));
               win_len   = CSR_DATA_BITS'($urandom);
               count     = 36;
            end
            4: begin
               trace_len = CSR_DATA_BITS'($urandom_range(30, 10));
               win_len   = 16'd1;
               count     = 36;
            end
            5: begin
               trace_len = CSR_DATA_BITS'($urandom_range(20, 3));
               win_len   = CSR_DATA_BITS'($urandom_range(127, 65));
               count     = 36;
            end
            default: begin
               trace_len = CSR_DATA_BITS'($urandom_range(70, 40));
               win_len   = CSR_DATA_BITS'($urandom_range(32, 8));
               count     = 40;
            end
         endcase
         configure(trace_len, win_len);
         set_pace(pace_mode_type'(p % 4));
         if (p == 2)
            hold_request = 1'b1;
         base = SAMPLE_W'($urandom);
         repeat (count) send_sample(random_sample(base));
      end

      wait_drained();
      if (sb.pending() != 0)
         sb.report($sformatf("%0d results never arrived", sb.pending()));
      if (sb.mismatches == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
